@@ hw/rtl/ucd_pkg.sv @@
// Shared types and constants for the UTF-8 code point decoder.
package ucd_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned COUNT_W = 3;
   localparam int unsigned CP_W    = 21;

   localparam logic [CP_W-1:0]    REPLACEMENT_CP = CP_W'(24'h00FFFD);
   localparam logic [COUNT_W-1:0] MAX_WINDOW     = 3'd4;

   // Lead and continuation byte patterns (value after masking) and masks
   localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD2_PAT  = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD3_PAT  = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
   localparam logic [BYTE_W-1:0] LEAD4_PAT  = 8'hF0;
   localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
   localparam logic [BYTE_W-1:0] CONT_PAT   = 8'h80;

   typedef enum logic [2:0] {
      LEAD_ASCII   = 3'd0,
      LEAD_TWO     = 3'd1,
      LEAD_THREE   = 3'd2,
      LEAD_FOUR    = 3'd3,
      LEAD_INVALID = 3'd4
   } lead_class_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  lead_byte;
      logic [BYTE_W-1:0]  second_byte;
      logic [BYTE_W-1:0]  third_byte;
      logic [BYTE_W-1:0]  fourth_byte;
      logic [COUNT_W-1:0] bytes_available;
   } req_word_type;

   typedef struct packed {
      logic [CP_W-1:0]    codepoint;
      logic [COUNT_W-1:0] bytes_consumed;
   } rsp_word_type;

endpackage

@@ hw/rtl/ucd_decode.sv @@
// Combinational decode of one UTF-8 window into code point and advance.
module ucd_decode (
   input  ucd_pkg::req_word_type win,
   output ucd_pkg::rsp_word_type res
);

   logic [ucd_pkg::COUNT_W-1:0] avail;
   ucd_pkg::lead_class_type     lclass;
   logic [ucd_pkg::COUNT_W-1:0] follow;
   logic                        c1, c2, c3;
   logic [ucd_pkg::CP_W-1:0]    value;

   // 5..7 saturate to 4
   assign avail = win.bytes_available[2] ? ucd_pkg::MAX_WINDOW : win.bytes_available;

   assign c1 = (win.second_byte & ucd_pkg::CONT_MASK) == ucd_pkg::CONT_PAT;
   assign c2 = (win.third_byte  & ucd_pkg::CONT_MASK) == ucd_pkg::CONT_PAT;
   assign c3 = (win.fourth_byte & ucd_pkg::CONT_MASK) == ucd_pkg::CONT_PAT;

   always_comb begin
      priority if (!win.lead_byte[7]) begin
         lclass = ucd_pkg::LEAD_ASCII;
      end else if ((win.lead_byte & ucd_pkg::LEAD2_MASK) == ucd_pkg::LEAD2_PAT) begin
         lclass = ucd_pkg::LEAD_TWO;
      end else if ((win.lead_byte & ucd_pkg::LEAD3_MASK) == ucd_pkg::LEAD3_PAT) begin
         lclass = ucd_pkg::LEAD_THREE;
      end else if ((win.lead_byte & ucd_pkg::LEAD4_MASK) == ucd_pkg::LEAD4_PAT) begin
         lclass = ucd_pkg::LEAD_FOUR;
      end else begin
         lclass = ucd_pkg::LEAD_INVALID;
      end
   end

   always_comb begin
      unique case (lclass)
         ucd_pkg::LEAD_TWO: begin
            follow = 3'd1;
            value  = {10'd0, win.lead_byte[4:0], win.second_byte[5:0]};
         end
         ucd_pkg::LEAD_THREE: begin
            follow = 3'd2;
            value  = {5'd0, win.lead_byte[3:0], win.second_byte[5:0],
                      win.third_byte[5:0]};
         end
         ucd_pkg::LEAD_FOUR: begin
            follow = 3'd3;
            value  = {win.lead_byte[2:0], win.second_byte[5:0],
                      win.third_byte[5:0], win.fourth_byte[5:0]};
         end
         default: begin
            follow = 3'd0;
            value  = {13'd0, win.lead_byte};
         end
      endcase
   end

   always_comb begin
      priority if (avail == 3'd0) begin
         res.codepoint      = '0;
         res.bytes_consumed = 3'd0;
      end else if (lclass == ucd_pkg::LEAD_ASCII) begin
         res.codepoint      = value;
         res.bytes_consumed = 3'd1;
      end else if (lclass == ucd_pkg::LEAD_INVALID) begin
         res.codepoint      = ucd_pkg::REPLACEMENT_CP;
         res.bytes_consumed = 3'd1;
      end else if (follow >= avail) begin
         // cut off by end of text: swallow the rest
         res.codepoint      = ucd_pkg::REPLACEMENT_CP;
         res.bytes_consumed = avail;
      end else if (!c1) begin
         res.codepoint      = ucd_pkg::REPLACEMENT_CP;
         res.bytes_consumed = 3'd1;
      end else if (follow >= 3'd2 && !c2) begin
         res.codepoint      = ucd_pkg::REPLACEMENT_CP;
         res.bytes_consumed = 3'd2;
      end else if (follow == 3'd3 && !c3) begin
         res.codepoint      = ucd_pkg::REPLACEMENT_CP;
         res.bytes_consumed = 3'd3;
      end else begin
         res.codepoint      = value;
         res.bytes_consumed = follow + 3'd1;
      end
   end

endmodule

@@ hw/rtl/utf8_codepoint_decoder_unit.sv @@
// Top level of the UTF-8 code point decoder: input register, decode, result register.
//
// Usage:
//  req channel: req_valid / req_stall / req_word carry one four-byte text window
//    plus the count of bytes left (saturated at four). A word is taken at a
//    rising edge with req_valid high and req_stall low.
//  rsp channel: rsp_valid / rsp_stall / rsp_word return the code point and the
//    number of bytes to advance, one result word for every request word, in order.
//  Path: a taken word passes the input register, then the result register, where
//    it shows on rsp_word; rsp_stall can hold it in either register.
//  Throughput: one word per cycle while rsp_stall is low, set by the single
//    decode stage between the two registers; a new word is taken while a finished
//    result waits, as long as the input register is empty.
//  Stall: when rsp_stall holds a result, the input register keeps its word and
//    req_stall rises only if that register is full as well.
//  Reset: synchronous, active high; both stages are emptied and no result is
//    presented until a new word arrives.
module utf8_codepoint_decoder_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ucd_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ucd_pkg::rsp_word_type rsp_word
);

   logic                  in_valid_ff, in_valid_in;
   ucd_pkg::req_word_type in_word_ff;
   logic                  out_valid_ff, out_valid_in;
   ucd_pkg::rsp_word_type out_word_ff;
   ucd_pkg::rsp_word_type dec_word;
   logic                  out_free;
   logic                  in_move;
   logic                  req_take;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign in_move   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !out_free);
   assign out_valid_in = in_move || (out_valid_ff && rsp_stall);

   ucd_decode u_decode (
      .win (in_word_ff),
      .res (dec_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= req_word;
      end
      if (in_move) begin
         out_word_ff <= dec_word;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff))
      else $error("request stalled with a free stage");

   a_move_fills_out: assert property (@(posedge clock) disable iff (reset)
      in_move |=> out_valid_ff)
      else $error("decoded word lost");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> (!out_valid_ff && !in_valid_ff))
      else $error("pipeline not empty after reset");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_word_ff.bytes_consumed <= ucd_pkg::MAX_WINDOW))
      else $error("advance beyond window");

   a_end_is_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_word_ff.bytes_consumed == 3'd0) |->
      (out_word_ff.codepoint == '0))
      else $error("nonzero code point with no advance");

endmodule
